/* src/tld_pkg.sv */
// tld_pkg: shared constants and types for the test tone level detector
// no dependencies; used by test_tone_level_detector
package tld_pkg;

  // field widths
  localparam int SampleW = 16;
  localparam int CoefW   = 16;
  localparam int ThreshW = 31;
  localparam int HoldW   = 16;
  localparam int LevelW  = 32;
  localparam int MulAW   = 17;
  localparam int MulBW   = 32;
  localparam int ProdW   = MulAW + MulBW;
  localparam int AccW    = 48;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 31;

  // register reset values
  localparam logic [CoefW-1:0]   CoefReset   = 16'd62259;
  localparam logic [ThreshW-1:0] ThreshReset = 31'd134217728;
  localparam logic [HoldW-1:0]   HoldReset   = 16'd300;

  // unity gain in Q1.16
  localparam logic [MulAW-1:0] CoefOne = 17'd65536;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_SMOOTHING_COEF  = 2'd0,
    REG_LEVEL_THRESHOLD = 2'd1,
    REG_HOLD_COUNT      = 2'd2
  } cfg_reg_t;

  // sequencer steps of the shared multiplier
  typedef enum logic [2:0] {
    STEP_I_SQ    = 3'd0,
    STEP_Q_SQ    = 3'd1,
    STEP_OLD     = 3'd2,
    STEP_NEW     = 3'd3,
    STEP_SUM     = 3'd4
  } step_t;

endpackage

/* src/test_tone_level_detector.sv */
// test_tone_level_detector: a new input is accepted only while idle, once the previous
// result has been loaded; the single shared 17x32 multiplier runs four products per
// item (I*I, Q*Q, coef*level, (1-coef)*envelope) followed by the sum and the compare.
// the output register lets the next item enter while a result waits.
// synchronous active-high reset: level 0, hold counter 300, registers to defaults.
// depends on tld_pkg
module test_tone_level_detector import tld_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [15:0] in_phase, [31:16] quadrature
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [0] tone_detected, [32:1] filtered_level, [39:33] zero
  // configuration write channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  typedef enum logic [1:0] {IDLE, RUN, FINISH} state_t;

  state_t               state;
  step_t                step;
  logic [CoefW-1:0]     smoothing_coef;
  logic [ThreshW-1:0]   level_threshold;
  logic [HoldW-1:0]     hold_count;
  logic [LevelW-1:0]    level;
  logic [HoldW-1:0]     hold_ctr;
  logic [HoldW-1:0]     hold_ctr_next;
  logic [SampleW-1:0]   mag_i;
  logic [SampleW-1:0]   mag_q;
  logic [LevelW-1:0]    env;
  logic [AccW-1:0]      acc;
  logic [AccW-1:0]      acc_sum;
  logic [ProdW-1:0]     prod;
  logic [MulAW-1:0]     mul_a;
  logic [MulBW-1:0]     mul_b;
  logic [SampleW-1:0]   in_phase;
  logic [SampleW-1:0]   quadrature;
  logic                 tone_detected;
  logic [LevelW-1:0]    filtered_level;
  logic                 out_free;

  assign in_phase   = s_tdata[15:0];
  assign quadrature = s_tdata[31:16];

  assign s_tready  = (state == IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;
  assign m_tdata   = {7'd0, filtered_level, tone_detected};

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step)
      STEP_I_SQ: begin
        mul_a = {1'b0, mag_i};
        mul_b = {16'd0, mag_i};
      end
      STEP_Q_SQ: begin
        mul_a = {1'b0, mag_q};
        mul_b = {16'd0, mag_q};
      end
      STEP_OLD: begin
        mul_a = {1'b0, smoothing_coef};
        mul_b = level;
      end
      STEP_NEW: begin
        mul_a = CoefOne - {1'b0, smoothing_coef};
        mul_b = env;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign acc_sum = acc + prod[AccW-1:0];

  // hold counter update from the new level
  always_comb begin
    if (level < {1'b0, level_threshold}) begin
      hold_ctr_next = hold_count;
    end else if (hold_ctr != '0) begin
      hold_ctr_next = hold_ctr - 1'b1;
    end else begin
      hold_ctr_next = hold_ctr;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      smoothing_coef  <= CoefReset;
      level_threshold <= ThreshReset;
      hold_count      <= HoldReset;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SMOOTHING_COEF:  smoothing_coef  <= cfg_data[CoefW-1:0];
        REG_LEVEL_THRESHOLD: level_threshold <= cfg_data[ThreshW-1:0];
        REG_HOLD_COUNT:      hold_count      <= cfg_data[HoldW-1:0];
        default: ;
      endcase
    end
  end

  // registered product of the shared multiplier
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // sequencer, datapath state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      step     <= STEP_I_SQ;
      level    <= '0;
      hold_ctr <= HoldReset;
      m_tvalid <= 1'b0;
    end else begin
      // drop the taken result unless a new one loads this cycle
      if (m_tvalid && m_tready && (state != FINISH)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (s_tvalid) begin
            mag_i <= in_phase[15] ? (~in_phase + 1'b1) : in_phase;
            mag_q <= quadrature[15] ? (~quadrature + 1'b1) : quadrature;
            step  <= STEP_I_SQ;
            state <= RUN;
          end
        end
        RUN: begin
          // accumulate the product of the previous step
          case (step)
            STEP_Q_SQ: env <= prod[LevelW-1:0];
            STEP_OLD:  env <= env + prod[LevelW-1:0];
            STEP_NEW:  acc <= prod[AccW-1:0];
            STEP_SUM:  level <= acc_sum[AccW-1:16];
            default: ;
          endcase
          if (step == STEP_SUM) begin
            state <= FINISH;
          end else begin
            step <= step_t'(step + 3'd1);
          end
        end
        FINISH: begin
          if (out_free) begin
            hold_ctr       <= hold_ctr_next;
            tone_detected  <= (hold_ctr_next == '0);
            filtered_level <= level;
            m_tvalid       <= 1'b1;
            step           <= STEP_I_SQ;
            state          <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule
